// ===== design/lzwse_pkg.sv =====
// Shared types and constants of the LZW stream encoder.
`timescale 1ns / 1ps
package lzwse_pkg;

  localparam logic [11:0] CODE_CLEAR = 12'd256;
  localparam logic [11:0] CODE_EOI   = 12'd257;
  localparam int          FIRST_FREE = 258;
  localparam int          MIN_WIDTH  = 9;
  localparam int          EPOCH_BITS = 3;
  localparam int          KEY_BITS   = 20;

  localparam logic REG_MIN_BITS = 1'b0;
  localparam logic REG_MAX_BITS = 1'b1;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DIRECT,
    ST_READ,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic [11:0] code;
    logic [3:0]  bits;
    logic        last;
  } result_t;

endpackage

// ===== design/lzw_stream_encoder_top.sv =====
// Top level of the LZW stream encoder with variable-width codes.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | mode, data_byte
//  out     | output    | out_valid/out_stall | code, code_bits, last_of_run
//  cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// A data byte takes one or more hash probes: each probe is a read of the
// hashed dictionary RAM (its read port) and a compare. End items and first bytes need no probe.
// After reset, and on every seventh dictionary restart, a clearing pass writes all
// 2^(DICT_ADDR_BITS+1) RAM rows, one per cycle (8192 at the default), with in_stall high.
// Results go to a 4-word queue; a queue with fewer than two free words holds the item in progress.
`timescale 1ns / 1ps
module lzw_stream_encoder_top #(
  parameter int DICT_ADDR_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] code,
  output logic [3:0]  code_bits,
  output logic        last_of_run,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);
  import lzwse_pkg::*;

  localparam int CB  = DICT_ADDR_BITS;
  localparam int NFB = DICT_ADDR_BITS + 1;
  localparam int HB  = DICT_ADDR_BITS + 1;
  localparam int WB  = $clog2(DICT_ADDR_BITS + 1);
  localparam int RW  = EPOCH_BITS + KEY_BITS + CB;
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = '1;

  state_t state, state_next;
  logic [EPOCH_BITS-1:0] epoch, epoch_next;
  logic [HB-1:0]  sweep_addr, sweep_addr_next;
  logic [HB-1:0]  probe_addr, probe_addr_next;
  logic           mode_r, mode_r_next;
  logic [7:0]     byte_r, byte_r_next;
  logic [CB-1:0]  match, match_next;
  logic [NFB-1:0] next_free, next_free_next;
  logic [WB-1:0]  cw, cw_next;
  logic           started, started_next;
  logic [3:0]     min_reg, max_reg;

  result_t        q [4];
  logic [1:0]     q_head, q_tail;
  logic [2:0]     q_count;
  logic [1:0]     push_cnt;
  result_t        push0, push1;
  logic           pop, room, restart;

  logic           ram_we;
  logic [HB-1:0]  ram_waddr;
  logic [RW-1:0]  ram_wdata, ram_rdata;
  logic [EPOCH_BITS-1:0] e_epoch;
  logic [KEY_BITS-1:0]   e_key, key_r;
  logic [CB-1:0]         e_code;

  logic [WB-1:0]  eff_max, eff_min, min_c;
  logic [NFB-1:0] limit, nf_inc;

  function automatic logic [WB-1:0] clamp_bits(input logic [3:0] v);
    if (int'(v) < MIN_WIDTH) begin
      return WB'(MIN_WIDTH);
    end else if (int'(v) > DICT_ADDR_BITS) begin
      return WB'(DICT_ADDR_BITS);
    end
    return WB'(v);
  endfunction

  function automatic logic [HB-1:0] hash(input logic [CB-1:0] m, input logic [7:0] b);
    return HB'(m) ^ (HB'(b) << (HB - 8));
  endfunction

  assign eff_max = clamp_bits(max_reg);
  assign min_c   = clamp_bits(min_reg);
  assign eff_min = (min_c > eff_max) ? eff_max : min_c;
  assign limit   = NFB'(1) << eff_max;
  assign nf_inc  = next_free + NFB'(1);

  assign key_r   = {12'(match), byte_r};
  assign e_epoch = ram_rdata[RW-1 -: EPOCH_BITS];
  assign e_key   = ram_rdata[CB +: KEY_BITS];
  assign e_code  = ram_rdata[CB-1:0];

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (q_count != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign room      = (q_count <= 3'd2);
  assign code        = q[q_head].code;
  assign code_bits   = q[q_head].bits;
  assign last_of_run = q[q_head].last;

  lzwse_ram #(
    .WIDTH(RW),
    .DEPTH(1 << HB)
  ) u_dict (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(probe_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_reg <= 4'd9;
      max_reg <= 4'd12;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_BITS: min_reg <= cfg_data;
        REG_MAX_BITS: max_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      epoch      <= EPOCH_BITS'(1);
      sweep_addr <= '0;
      next_free  <= NFB'(FIRST_FREE);
      match      <= '0;
      cw         <= WB'(MIN_WIDTH);
      started    <= 1'b0;
    end else begin
      state      <= state_next;
      epoch      <= epoch_next;
      sweep_addr <= sweep_addr_next;
      next_free  <= next_free_next;
      match      <= match_next;
      cw         <= cw_next;
      started    <= started_next;
    end
  end

  always_ff @(posedge clk) begin
    probe_addr <= probe_addr_next;
    mode_r     <= mode_r_next;
    byte_r     <= byte_r_next;
  end

  always_comb begin
    state_next      = state;
    epoch_next      = epoch;
    sweep_addr_next = sweep_addr;
    probe_addr_next = probe_addr;
    mode_r_next     = mode_r;
    byte_r_next     = byte_r;
    match_next      = match;
    next_free_next  = next_free;
    cw_next         = cw;
    started_next    = started;
    ram_we          = 1'b0;
    ram_waddr       = sweep_addr;
    ram_wdata       = '0;
    push_cnt        = 2'd0;
    push0           = '0;
    push1           = '0;
    restart         = 1'b0;

    unique case (state)
      ST_SWEEP: begin
        ram_we          = 1'b1;
        sweep_addr_next = sweep_addr + HB'(1);
        if (sweep_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          mode_r_next     = mode;
          byte_r_next     = data_byte;
          probe_addr_next = hash(match, data_byte);
          state_next      = (mode || !started) ? ST_DIRECT : ST_READ;
        end
      end
      ST_DIRECT: begin
        if (room) begin
          state_next = ST_IDLE;
          if (mode_r) begin
            push_cnt = 2'd2;
            if (started) begin
              push0 = '{code: 12'(match), bits: 4'(cw), last: 1'b0};
              push1 = '{code: CODE_EOI, bits: 4'(cw), last: 1'b1};
            end else begin
              restart = 1'b1;
              push0 = '{code: CODE_CLEAR, bits: 4'(eff_min), last: 1'b0};
              push1 = '{code: CODE_EOI, bits: 4'(eff_min), last: 1'b1};
            end
            started_next = 1'b0;
          end else begin
            restart      = 1'b1;
            started_next = 1'b1;
            match_next   = CB'(byte_r);
            push_cnt     = 2'd1;
            push0 = '{code: CODE_CLEAR, bits: 4'(eff_min), last: 1'b1};
          end
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (e_epoch == epoch && e_key == key_r) begin
          match_next = e_code;
          state_next = ST_IDLE;
        end else if (e_epoch != epoch) begin
          if (room) begin
            state_next = ST_IDLE;
            match_next = CB'(byte_r);
            if (next_free < limit) begin
              push_cnt       = 2'd1;
              push0 = '{code: 12'(match), bits: 4'(cw), last: 1'b1};
              ram_we         = 1'b1;
              ram_waddr      = probe_addr;
              ram_wdata      = {epoch, key_r, CB'(next_free)};
              next_free_next = nf_inc;
              if (cw < eff_max && nf_inc > (NFB'(1) << cw)) begin
                cw_next = cw + WB'(1);
              end
            end else begin
              push_cnt = 2'd2;
              push0 = '{code: 12'(match), bits: 4'(cw), last: 1'b0};
              push1 = '{code: CODE_CLEAR, bits: 4'(cw), last: 1'b1};
              restart  = 1'b1;
            end
          end
        end else begin
          probe_addr_next = probe_addr + HB'(1);
          state_next      = ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (restart) begin
      next_free_next = NFB'(FIRST_FREE);
      cw_next        = eff_min;
      if (epoch == EPOCH_LAST) begin
        epoch_next      = EPOCH_BITS'(1);
        sweep_addr_next = '0;
        state_next      = ST_SWEEP;
      end else begin
        epoch_next = epoch + EPOCH_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else begin
      q_head  <= q_head + 2'(pop);
      q_tail  <= q_tail + push_cnt;
      q_count <= q_count + 3'(push_cnt) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q[q_tail] <= push0;
    end
    if (push_cnt == 2'd2) begin
      q[q_tail + 2'd1] <= push1;
    end
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst) q_count <= 3'd4)
    else $error("result queue overflow");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != ST_IDLE))
    else $error("accepted word not taken into work");
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst) epoch != '0)
    else $error("epoch matches cleared rows");
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (push_cnt != 2'd0) |-> (q_count <= 3'd2))
    else $error("push without queue room");
`endif

endmodule

// ===== design/lzwse_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module lzwse_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
